// File: hw/rtl/aoc_pkg.sv
// Shared constants for the alpha-over compositor.
// No dependencies; imported by every module of the block.
package aoc_pkg;

  localparam int CHANNEL_BITS_DEF = 8;

endpackage

// File: hw/rtl/alpha_over_composite.sv
// Porter-Duff source-over of straight-alpha pixels, one pixel per word.
// One word per cycle sustained while the output is not stalled, set by the
// per-stage divider pipeline, one quotient bit per stage.
// Stalls collapse bubbles: a stage loads whenever it or a later stage is empty.
// Synchronous active-low reset clears only the stage valid bits.
// Depends on aoc_pkg, aoc_lane, aoc_div and aoc_merge.
module alpha_over_composite import aoc_pkg::*; #(
  parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // src_red, src_green, src_blue, src_alpha, dst_red, dst_green, dst_blue, dst_alpha
  input  logic [8*CHANNEL_BITS-1:0]           in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // out_red, out_green, out_blue, out_alpha, zero pad
  output logic [((4*CHANNEL_BITS+7)/8)*8-1:0] out_tdata,
  // fully_clear
  output logic                                out_tuser
);

  localparam int CB   = CHANNEL_BITS;
  localparam int QB   = CB + 1;
  localparam int NS   = QB + 4;
  localparam int PW   = 2 * CB;
  localparam int ODW  = ((4 * CB + 7) / 8) * 8;
  localparam logic [CB-1:0] CH_MAX = '1;
  localparam logic [PW-1:0] A_HALF = PW'((1 << (CB - 1)) - 1);

  logic [NS-1:0] rdy;
  logic [NS-1:0] vld_r;
  logic [NS-1:0] vld_in;
  logic [NS-2:0] clr_r;
  logic [NS-2:0] clr_in;

  logic [CB-1:0] src [3];
  logic [CB-1:0] dst [3];
  logic [CB-1:0] sa;
  logic [CB-1:0] da;
  logic [CB-1:0] msa;
  logic [PW-1:0] w_c;

  logic [CB-1:0] s_r [3];
  logic [CB-1:0] d_r [3];
  logic [CB-1:0] sa_r;
  logic [PW-1:0] wd_r;
  logic [PW-1:0] w_r;
  logic [PW-1:0] w2_r;
  logic [PW-1:0] ax;
  logic [PW-1:0] aq;
  logic [CB-1:0] alpha_r;
  logic [CB-1:0] adly_r [QB];

  logic [QB-1:0] quo [4];
  logic [CB-1:0] red_o, green_o, blue_o, alpha_o;

  // stall control
  for (genvar k = 0; k < NS; k++) begin : g_rdy
    assign rdy[k] = out_tready || !(&vld_r[NS-1:k]);
  end

  assign vld_in = {vld_r[NS-2:0], in_tvalid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (rdy[k]) begin
          vld_r[k] <= vld_in[k];
        end
      end
    end
  end

  assign in_tready  = rdy[0];
  assign out_tvalid = vld_r[NS-1];

  // front: unpack and weighted alpha
  for (genvar c = 0; c < 3; c++) begin : g_unpack
    assign src[c] = in_tdata[c*CB +: CB];
    assign dst[c] = in_tdata[(c+4)*CB +: CB];
  end
  assign sa  = in_tdata[3*CB +: CB];
  assign da  = in_tdata[7*CB +: CB];
  assign msa = CH_MAX - sa;
  assign w_c = {sa, {CB{1'b0}}} - PW'(sa) + PW'(da) * PW'(msa);

  // rounded W / M: x / M as (x + (x >> CB) + 1) >> CB
  assign ax = w2_r + A_HALF;
  assign aq = ax + PW'(ax[PW-1:CB]) + PW'(1);

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      for (int c = 0; c < 3; c++) begin
        s_r[c] <= src[c];
        d_r[c] <= dst[c];
      end
      sa_r <= sa;
      wd_r <= PW'(da) * PW'(msa);
      w_r  <= w_c;
    end
    if (rdy[1]) begin
      w2_r <= w_r;
    end
    if (rdy[2]) begin
      alpha_r <= CB'(aq >> CB);
    end
  end

  // alpha waits alongside the colour dividers
  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      adly_r[0] <= alpha_r;
    end
    for (int k = 1; k < QB; k++) begin
      if (rdy[k+3]) begin
        adly_r[k] <= adly_r[k-1];
      end
    end
  end

  assign quo[3] = {1'b0, adly_r[QB-1]};

  // zero weighted alpha flag rides alongside the lanes
  assign clr_in = {clr_r[NS-3:0], (sa == '0) && (da == '0)};

  always_ff @(posedge clk) begin
    for (int k = 0; k < NS - 1; k++) begin
      if (rdy[k]) begin
        clr_r[k] <= clr_in[k];
      end
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_lane
    aoc_lane #(.CHANNEL_BITS(CHANNEL_BITS)) u_lane (
      .clk   (clk),
      .en    (rdy[QB+2:1]),
      .src_i (s_r[c]),
      .dst_i (d_r[c]),
      .sa_i  (sa_r),
      .wd_i  (wd_r),
      .w_i   (w2_r),
      .quo_o (quo[c])
    );
  end

  aoc_merge #(.CHANNEL_BITS(CHANNEL_BITS)) u_merge (
    .clk     (clk),
    .en      (rdy[NS-1]),
    .red_q   (quo[0]),
    .green_q (quo[1]),
    .blue_q  (quo[2]),
    .alpha_q (quo[3]),
    .clear_i (clr_r[NS-2]),
    .red_o   (red_o),
    .green_o (green_o),
    .blue_o  (blue_o),
    .alpha_o (alpha_o),
    .clear_o (out_tuser)
  );

  assign out_tdata = ODW'({alpha_o, blue_o, green_o, red_o});

endmodule

// File: hw/rtl/aoc_div.sv
// Pipelined restoring divider, one quotient bit per stage, stalled per stage.
// Depends on aoc_pkg.
module aoc_div import aoc_pkg::*; #(
  parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
  input  logic                      clk,
  input  logic [CHANNEL_BITS:0]     en,
  input  logic [3*CHANNEL_BITS+1:0] num_i,
  input  logic [2*CHANNEL_BITS:0]   den_i,
  output logic [CHANNEL_BITS:0]     quo_o
);

  localparam int QB  = CHANNEL_BITS + 1;
  localparam int NW  = 3 * CHANNEL_BITS + 2;
  localparam int DVW = 2 * CHANNEL_BITS + 1;
  localparam int TW  = NW + 1;

  logic [NW-1:0]  rem_r [QB-1];
  logic [DVW-1:0] den_r [QB-1];
  logic [QB-1:0]  quo_r [QB];

  for (genvar j = 0; j < QB; j++) begin : g_stage
    localparam int SH = QB - 1 - j;
    logic [NW-1:0]  rem_in;
    logic [DVW-1:0] den_in;
    logic [QB-1:0]  quo_in;
    logic [TW-1:0]  trial;

    if (j == 0) begin : g_first
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[j-1];
      assign den_in = den_r[j-1];
      assign quo_in = quo_r[j-1];
    end

    assign trial = {1'b0, rem_in} - (TW'(den_in) << SH);

    always_ff @(posedge clk) begin
      if (en[j]) begin
        quo_r[j] <= {quo_in[QB-2:0], ~trial[NW]};
      end
    end

    if (j < QB - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en[j]) begin
          rem_r[j] <= trial[NW] ? rem_in : trial[NW-1:0];
          den_r[j] <= den_in;
        end
      end
    end
  end

  assign quo_o = quo_r[QB-1];

endmodule

// File: hw/rtl/aoc_lane.sv
// One colour lane: weighted numerator, rounding offset, then the divider.
// Depends on aoc_pkg and aoc_div.
module aoc_lane import aoc_pkg::*; #(
  parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
  input  logic                      clk,
  input  logic [CHANNEL_BITS+2:0]   en,
  input  logic [CHANNEL_BITS-1:0]   src_i,
  input  logic [CHANNEL_BITS-1:0]   dst_i,
  input  logic [CHANNEL_BITS-1:0]   sa_i,
  input  logic [2*CHANNEL_BITS-1:0] wd_i,
  input  logic [2*CHANNEL_BITS-1:0] w_i,
  output logic [CHANNEL_BITS:0]     quo_o
);

  localparam int CB  = CHANNEL_BITS;
  localparam int PW  = 2 * CB;
  localparam int QW  = 3 * CB;
  localparam int NW  = 3 * CB + 2;
  localparam int DVW = 2 * CB + 1;

  logic [PW-1:0]  ps_r;
  logic [QW-1:0]  pd_r;
  logic [NW-1:0]  num_c;
  logic [NW-1:0]  num_r;
  logic [DVW-1:0] den_r;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      ps_r <= PW'(src_i) * PW'(sa_i);
      pd_r <= QW'(dst_i) * QW'(wd_i);
    end
  end

  // s*sa*M as (x << CB) - x, plus d*da*(M - sa)
  assign num_c = NW'({ps_r, {CB{1'b0}}}) - NW'(ps_r) + NW'(pd_r);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      num_r <= (num_c << 1) + NW'(w_i);
      den_r <= {w_i, 1'b0};
    end
  end

  aoc_div #(.CHANNEL_BITS(CHANNEL_BITS)) u_div (
    .clk   (clk),
    .en    (en[CB+2:2]),
    .num_i (num_r),
    .den_i (den_r),
    .quo_o (quo_o)
  );

endmodule

// File: hw/rtl/aoc_merge.sv
// Output stage: clamps the four lane quotients and forces transparent black when clear.
// Depends on aoc_pkg.
module aoc_merge import aoc_pkg::*; #(
  parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic [CHANNEL_BITS:0]   red_q,
  input  logic [CHANNEL_BITS:0]   green_q,
  input  logic [CHANNEL_BITS:0]   blue_q,
  input  logic [CHANNEL_BITS:0]   alpha_q,
  input  logic                    clear_i,
  output logic [CHANNEL_BITS-1:0] red_o,
  output logic [CHANNEL_BITS-1:0] green_o,
  output logic [CHANNEL_BITS-1:0] blue_o,
  output logic [CHANNEL_BITS-1:0] alpha_o,
  output logic                    clear_o
);

  localparam int CB = CHANNEL_BITS;
  localparam int QB = CB + 1;
  localparam logic [CB-1:0] CH_MAX = '1;

  function automatic logic [CB-1:0] sat(input logic [QB-1:0] q, input logic clr);
    logic [CB-1:0] v;
    v = (q > QB'(CH_MAX)) ? CH_MAX : q[CB-1:0];
    return clr ? '0 : v;
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      red_o   <= sat(red_q, clear_i);
      green_o <= sat(green_q, clear_i);
      blue_o  <= sat(blue_q, clear_i);
      alpha_o <= sat(alpha_q, clear_i);
      clear_o <= clear_i;
    end
  end

endmodule

// File: hw/rtl/aoc_chk.sv
// Port-level checker for the alpha-over compositor, bound to the top level.
// Depends on aoc_pkg and alpha_over_composite.
module aoc_chk import aoc_pkg::*; #(
  parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_tready,
  input logic                                out_tvalid,
  input logic                                out_tready,
  input logic [((4*CHANNEL_BITS+7)/8)*8-1:0] out_tdata,
  input logic                                out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  a_clear_black: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("fully clear word is not transparent black");

  a_ready_flow: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input stalled while output drains");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind alpha_over_composite aoc_chk #(.CHANNEL_BITS(CHANNEL_BITS)) u_aoc_chk (.*);
